>>> hw/rtl/nta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants of the nearest track association table.
// ----------------------------------------------------------------------------
package nta_pkg;

  // field widths
  localparam int unsigned PosW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned GateW    = 16;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CountW   = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_GATE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_RETIRE = 1'b1;

  // operation codes
  localparam logic OP_OBSERVE  = 1'b0;
  localparam logic OP_SCAN_END = 1'b1;

  // reset values of the registers
  localparam logic [GateW-1:0] GATE_RESET   = 16'd200;
  localparam logic [TimeW-1:0] RETIRE_RESET = 32'd1000;

  // one table entry as held by a cell
  typedef struct packed {
    logic [PosW-1:0]  x;
    logic [PosW-1:0]  y;
    logic [PosW-1:0]  heading;
    logic [TimeW-1:0] seen;
    logic             dead;
  } entry_t;

  // what the cells do in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_ROT   = 2'd1,
    CELL_SWAP  = 2'd2,
    CELL_WRITE = 2'd3
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       parity;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/nta_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------

// input item channel
interface nta_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  logic [31:0] now;
  modport source (output valid, op, pos_x, pos_y, heading, now, input ready);
  modport sink   (input valid, op, pos_x, pos_y, heading, now, output ready);
endinterface

// result channel
interface nta_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot;
  logic       inserted;
  logic       dropped;
  logic [5:0] retired;
  logic [5:0] occupancy;
  modport source (output valid, slot, inserted, dropped, retired, occupancy, input ready);
  modport sink   (input valid, slot, inserted, dropped, retired, occupancy, output ready);
endinterface

// register write channel
interface nta_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/nta_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_cell
// One table entry; rotates toward the head, swaps with a neighbor during
// compaction, or loads a new entry.
// ----------------------------------------------------------------------------
module nta_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  wire                      clk_i,
  input  wire nta_pkg::cell_ctrl_t ctrl_i,
  input  wire [IDX_W-1:0]          wr_idx_i,
  input  wire nta_pkg::entry_t     wr_entry_i,
  input  wire nta_pkg::entry_t     next_i,
  input  wire nta_pkg::entry_t     prev_i,
  output nta_pkg::entry_t          entry_o
);
  import nta_pkg::*;

  localparam logic LeftPar  = 1'(INDEX % 2);
  localparam logic RightPar = 1'((INDEX + 1) % 2);
  localparam bit   HasRight = (INDEX < DEPTH - 1);
  localparam bit   HasLeft  = (INDEX > 0);

  entry_t entry_q, entry_d;

  // next value of the entry
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.mode)
      CELL_ROT: entry_d = next_i;
      CELL_SWAP: begin
        if (HasRight && ctrl_i.parity == LeftPar) begin
          if (entry_q.dead && !next_i.dead) entry_d = next_i;
          else if (entry_q.dead && next_i.dead) entry_d = entry_q;
        end
        if (HasLeft && ctrl_i.parity == RightPar) begin
          if (prev_i.dead && !entry_q.dead) entry_d = prev_i;
        end
      end
      CELL_WRITE: begin
        if (wr_idx_i == IDX_W'(INDEX)) entry_d = wr_entry_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

>>> hw/rtl/nearest_track_association_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_track_association_table
// Gated nearest-neighbor track table built from a ring of entry cells.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_DEPTH cells that rotates one place per
// cycle past a single head unit during a rotation. An observation goes from
// transfer to result through one full rotation through the distance unit,
// one pipeline drain and one write; a scan end makes a full rotation marking
// stale entries, then TABLE_DEPTH odd-even neighbor swap phases that compact
// the survivors in order. One item is worked on at a time; a new item is
// taken while a finished result waits at the output. Registers are to be
// written only while the block is idle; the block does not enforce this.
module nearest_track_association_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  nta_in_if.sink        in_i,
  nta_out_if.source     out_o,
  nta_cfg_if.sink       cfg_i
);
  import nta_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROT   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_SORT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // registers
  logic [GateW-1:0] gate_q;
  logic [TimeW-1:0] retire_q;

  // control
  logic [IDX_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] retired_q, retired_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] win_q, win_d;
  logic             s1_v_q, s1_v_d;

  // payload
  logic             op_q;
  logic [PosW-1:0]  x_q, y_q, hd_q;
  logic [TimeW-1:0] now_q;
  logic [32:0]      best_q, best_d;
  logic [31:0]      sqx_q, sqy_q;
  logic [IDX_W-1:0] s1_idx_q;

  // result holding
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic              res_ins_q, res_ins_d, res_drop_q, res_drop_d;
  logic [CountW-1:0] res_ret_q, res_ret_d, res_occ_q, res_occ_d;
  logic              out_valid_q;

  entry_t     cells [TABLE_DEPTH];
  entry_t     tail, wr_entry;
  cell_ctrl_t ctrl;
  logic [IDX_W-1:0] wr_idx;

  logic in_xfer, out_xfer, last_k, k_live, full, stale;
  logic [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic [32:0] sq_dist;
  logic [TimeW-1:0] age;
  logic [IDX_W+SlotW-1:0]   slot_ext;
  logic [CNT_W+CountW-1:0]  occ_ext, ret_ext;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_valid_q && out_o.ready;

  assign last_k = (k_q == IDX_W'(TABLE_DEPTH - 1));
  assign k_live = (CNT_W'(k_q) < count_q);
  assign full   = (count_q == CNT_W'(TABLE_DEPTH));

  // head unit: distance of the head entry to the observation
  assign dx      = {x_q[15], x_q} - {cells[0].x[15], cells[0].x};
  assign dy      = {y_q[15], y_q} - {cells[0].y[15], cells[0].y};
  assign adx     = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady     = dy[16] ? 16'(-dy) : dy[15:0];
  assign sq_dist = {1'b0, sqx_q} + {1'b0, sqy_q};

  // head unit: age of the head entry
  assign age   = now_q - cells[0].seen;
  assign stale = (age > retire_q);

  // entry leaving the head re-enters at the tail
  always_comb begin
    tail = cells[0];
    if (op_q == OP_SCAN_END) tail.dead = !k_live || stale;
  end

  // new entry for a write
  always_comb begin
    wr_entry.x       = x_q;
    wr_entry.y       = y_q;
    wr_entry.heading = hd_q;
    wr_entry.seen    = now_q;
    wr_entry.dead    = 1'b0;
  end

  assign wr_idx = found_q ? win_q : count_q[IDX_W-1:0];

  // cell control
  always_comb begin
    ctrl.mode   = CELL_HOLD;
    ctrl.parity = k_q[0];
    case (state_q)
      ST_ROT:   ctrl.mode = CELL_ROT;
      ST_SORT:  ctrl.mode = CELL_SWAP;
      ST_WRITE: ctrl.mode = (found_q || !full) ? CELL_WRITE : CELL_HOLD;
      default:  ctrl.mode = CELL_HOLD;
    endcase
  end

  // ring of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nta_cell #(
      .INDEX (i),
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .wr_idx_i   (wr_idx),
      .wr_entry_i (wr_entry),
      .next_i     ((i < TABLE_DEPTH - 1) ? cells[(i + 1) % TABLE_DEPTH] : tail),
      .prev_i     ((i > 0) ? cells[(i + TABLE_DEPTH - 1) % TABLE_DEPTH] : cells[0]),
      .entry_o    (cells[i])
    );
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    count_d    = count_q;
    retired_d  = retired_q;
    found_d    = found_q;
    win_d      = win_q;
    best_d     = best_q;
    s1_v_d     = 1'b0;
    res_slot_d = res_slot_q;
    res_ins_d  = res_ins_q;
    res_drop_d = res_drop_q;
    res_ret_d  = res_ret_q;
    res_occ_d  = res_occ_q;
    slot_ext   = '0;
    occ_ext    = '0;
    ret_ext    = '0;

    // compare stage of the distance pipeline
    if (s1_v_q && sq_dist < best_q) begin
      best_d  = sq_dist;
      win_d   = s1_idx_q;
      found_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d   = ST_ROT;
          k_d       = '0;
          retired_d = '0;
          found_d   = 1'b0;
          win_d     = '0;
          best_d    = {1'b0, 32'(gate_q) * 32'(gate_q)};
        end
      end
      ST_ROT: begin
        s1_v_d = (op_q == OP_OBSERVE) && k_live;
        if (op_q == OP_SCAN_END && k_live && stale) retired_d = retired_q + 1'b1;
        k_d = k_q + 1'b1;
        if (last_k) begin
          k_d     = '0;
          state_d = (op_q == OP_OBSERVE) ? ST_DRAIN : ST_SORT;
        end
      end
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: begin
        res_ins_d  = 1'b0;
        res_drop_d = 1'b0;
        slot_ext   = {{SlotW{1'b0}}, win_q};
        if (!found_q) begin
          if (!full) begin
            slot_ext  = {{SlotW{1'b0}}, count_q[IDX_W-1:0]};
            count_d   = count_q + 1'b1;
            res_ins_d = 1'b1;
          end else begin
            slot_ext   = '0;
            res_drop_d = 1'b1;
          end
        end
        occ_ext    = {{CountW{1'b0}}, count_d};
        res_slot_d = slot_ext[SlotW-1:0];
        res_occ_d  = occ_ext[CountW-1:0];
        res_ret_d  = '0;
        state_d    = ST_FIN;
      end
      ST_SORT: begin
        k_d = k_q + 1'b1;
        if (last_k) begin
          k_d        = '0;
          count_d    = count_q - retired_q;
          occ_ext    = {{CountW{1'b0}}, count_d};
          ret_ext    = {{CountW{1'b0}}, retired_q};
          res_slot_d = '0;
          res_ins_d  = 1'b0;
          res_drop_d = 1'b0;
          res_occ_d  = occ_ext[CountW-1:0];
          res_ret_d  = ret_ext[CountW-1:0];
          state_d    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      count_q     <= '0;
      retired_q   <= '0;
      found_q     <= 1'b0;
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      gate_q      <= GATE_RESET;
      retire_q    <= RETIRE_RESET;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      count_q   <= count_d;
      retired_q <= retired_d;
      found_q   <= found_d;
      s1_v_q    <= s1_v_d;
      if (state_q == ST_FIN && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_GATE:   gate_q   <= cfg_i.data[GateW-1:0];
          REG_RETIRE: retire_q <= cfg_i.data[TimeW-1:0];
          default:    gate_q   <= gate_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= in_i.op;
      x_q   <= in_i.pos_x;
      y_q   <= in_i.pos_y;
      hd_q  <= in_i.heading;
      now_q <= in_i.now;
    end
    best_q     <= best_d;
    win_q      <= win_d;
    sqx_q      <= adx * adx;
    sqy_q      <= ady * ady;
    s1_idx_q   <= k_q;
    res_slot_q <= res_slot_d;
    res_ins_q  <= res_ins_d;
    res_drop_q <= res_drop_d;
    res_ret_q  <= res_ret_d;
    res_occ_q  <= res_occ_d;
    if (state_q == ST_FIN && (!out_valid_q || out_o.ready)) begin
      out_o.slot      <= res_slot_q;
      out_o.inserted  <= res_ins_q;
      out_o.dropped   <= res_drop_q;
      out_o.retired   <= res_ret_q;
      out_o.occupancy <= res_occ_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_retired_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT || state_q == ST_SORT) |-> retired_q <= count_q)
    else $error("more entries retired than held");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_ROT)
    else $error("accepted item did not start a rotation");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_o.inserted && out_o.dropped))
    else $error("result both inserted and dropped");

endmodule
`default_nettype wire
